// ----- hdl/flm_pkg.sv -----
// Shared types and constants of the flow loss monitor.
`default_nettype none
package flm_pkg;
   localparam int FLOWS        = 16;
   localparam int SLOT_W       = $clog2(FLOWS);
   localparam int HIST_DEPTH   = 8;
   localparam int HIST_W       = $clog2(HIST_DEPTH);
   localparam int FILL_W       = HIST_W + 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam logic [3:0] DEPTH_RESET = 4'd8;
   localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;

   localparam logic [2:0] EV_COUNTED = 3'd0;
   localparam logic [2:0] EV_NEW     = 3'd1;
   localparam logic [2:0] EV_RESTART = 3'd2;
   localparam logic [2:0] EV_GAP     = 3'd3;
   localparam logic [2:0] EV_FULL    = 3'd4;
   localparam logic [2:0] EV_CLEARED = 3'd5;

   typedef enum logic [1:0] {K_CLEAR, K_FULL, K_NEW, K_HIT} kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [SLOT_W-1:0]  slot;
      logic [31:0]        session_id;
      logic [31:0]        seq;
      logic [15:0]        send_interval_sec;
      logic [31:0]        now_sec;
      logic [19:0]        now_usec;
   } item_type;
endpackage
`default_nettype wire

// ----- hdl/flm_channels.sv -----
// Channel interfaces of the flow loss monitor.
`default_nettype none
interface flm_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic [31:0] session_id;
   logic [31:0] seq;
   logic [15:0] send_interval_sec;
   logic [31:0] now_sec;
   logic [19:0] now_usec;
   modport source (output valid, mode, addr_high, addr_low, session_id, seq,
                   send_interval_sec, now_sec, now_usec, input ready);
   modport sink (input valid, mode, addr_high, addr_low, session_id, seq,
                 send_interval_sec, now_sec, now_usec, output ready);
endinterface

interface flm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [3:0]  flow_slot;
   logic [31:0] gap_packets;
   logic [31:0] packet_total;
   logic [31:0] loss_events;
   logic [31:0] lost_total;
   logic [31:0] sample_count;
   modport source (output valid, event_res, flow_slot, gap_packets, packet_total,
                   loss_events, lost_total, sample_count, input ready);
   modport sink (input valid, event_res, flow_slot, gap_packets, packet_total,
                 loss_events, lost_total, sample_count, output ready);
endinterface

interface flm_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] history_depth;
   modport source (output valid, history_depth, input ready);
   modport sink (input valid, history_depth, output ready);
endinterface
`default_nettype wire

// ----- hdl/flm_front.sv -----
// Front end: flow table match, slot allocation and classification.
`default_nettype none
module flm_front
   import flm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   flm_req_if.sink   req,
   input  wire logic q_full,
   output logic      push,
   output item_type  push_item
);
   logic [FLOWS-1:0]  valid_ff;
   logic [63:0]       addr_high_ff [FLOWS];
   logic [63:0]       addr_low_ff  [FLOWS];
   logic              hit, free;
   logic [SLOT_W-1:0] hit_slot, free_slot;

   always_comb begin
      hit = 1'b0;
      free = 1'b0;
      hit_slot = '0;
      free_slot = '0;
      for (int i = FLOWS - 1; i >= 0; i--) begin
         if (valid_ff[i] && addr_high_ff[i] == req.addr_high
             && addr_low_ff[i] == req.addr_low) begin
            hit = 1'b1;
            hit_slot = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   always_comb begin
      push_item.session_id        = req.session_id;
      push_item.seq               = req.seq;
      push_item.send_interval_sec = req.send_interval_sec;
      push_item.now_sec           = req.now_sec;
      push_item.now_usec          = req.now_usec;
      push_item.slot              = '0;
      if (req.mode) begin
         push_item.kind = K_CLEAR;
      end else if (hit) begin
         push_item.kind = K_HIT;
         push_item.slot = hit_slot;
      end else if (free) begin
         push_item.kind = K_NEW;
         push_item.slot = free_slot;
      end else begin
         push_item.kind = K_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (push && push_item.kind == K_NEW) begin
         valid_ff[free_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_item.kind == K_NEW) begin
         addr_high_ff[free_slot] <= req.addr_high;
         addr_low_ff[free_slot]  <= req.addr_low;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/flm_queue.sv -----
// Short queue of classified items between front and back end.
`default_nettype none
module flm_queue
   import flm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output logic          full,
   output logic          not_empty,
   output item_type      head_item
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [PTR_W:0]     count_ff;

   assign full      = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_item = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_item;
   end
endmodule
`default_nettype wire

// ----- hdl/flm_back.sv -----
// Back end: per-flow counters, loss history and interval statistics.
`default_nettype none
module flm_back
   import flm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic [3:0] history_depth,
   input  wire logic     q_not_empty,
   input  wire item_type q_item,
   output logic          pop,
   flm_rsp_if.source     rsp
);
   typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_SUM, ST_SQUARE, ST_COMMIT} state_type;

   state_type state_ff;
   item_type  op_ff;

   logic [31:0] session_ff  [FLOWS];
   logic [31:0] lseq_ff     [FLOWS];
   logic [31:0] lsec_ff     [FLOWS];
   logic [19:0] lusec_ff    [FLOWS];
   logic [31:0] pkt_ff      [FLOWS];
   logic [31:0] gapcnt_ff   [FLOWS];
   logic [31:0] lost_ff     [FLOWS];
   logic [15:0] ovf_ff      [FLOWS];
   logic [HIST_W-1:0] head_ff [FLOWS];
   logic [FILL_W-1:0] fill_ff [FLOWS];
   logic [31:0] samples_ff  [FLOWS];
   logic signed [63:0] sum_ff [FLOWS];
   logic [63:0] sqsum_ff    [FLOWS];

   logic [63:0] hist_mem [FLOWS*HIST_DEPTH];
   logic [63:0] hist_rd_ff;

   logic        restart_ff, gap_hit_ff, lseq_nz_ff;
   logic [31:0] gap_val_ff, start_ff, length_ff;
   logic signed [53:0] prod_ff;
   logic signed [20:0] udiff_ff;
   logic signed [54:0] t_ff;
   logic [63:0] sq_ff;
   logic signed [63:0] sum_new_ff;

   logic        rsp_valid_ff;
   logic [2:0]  ev_ff;
   logic [3:0]  slot_out_ff;
   logic [31:0] gap_out_ff, pkt_out_ff, loss_out_ff, lost_out_ff, samp_out_ff;

   logic [SLOT_W-1:0] s;
   logic [HIST_W-1:0] dm1;
   logic              commit;
   logic signed [32:0] dsec;
   logic [31:0]       start_in;
   logic [54:0]       mag;
   logic signed [64:0] sum65;
   logic [64:0]       sq65;
   logic [63:0]       sqsum_in;
   logic              shift, ovf_hit;
   logic [31:0]       pkt_in, gapcnt_in, lost_in, samp_in;
   logic [2:0]        ev_in;

   assign s   = op_ff.slot;
   assign dm1 = (history_depth == 4'd0) ? '0 :
                (history_depth > 4'(HIST_DEPTH)) ? HIST_W'(HIST_DEPTH - 1) :
                HIST_W'(history_depth - 4'd1);
   assign pop    = state_ff == ST_IDLE && q_not_empty;
   assign commit = state_ff == ST_COMMIT && (!rsp_valid_ff || rsp.ready);

   assign dsec     = $signed({1'b0, op_ff.now_sec}) - $signed({1'b0, lsec_ff[s]});
   assign start_in = lsec_ff[s] + 32'(op_ff.send_interval_sec);
   assign mag      = t_ff[54] ? 55'(-t_ff) : 55'(t_ff);
   assign sum65    = 65'(sum_ff[s]) + 65'(t_ff);
   assign sq65     = {1'b0, sqsum_ff[s]} + {1'b0, sq_ff};
   assign sqsum_in = sq65[64] ? '1 : sq65[63:0];
   assign shift    = op_ff.kind == K_HIT && (restart_ff || gap_hit_ff);
   assign ovf_hit  = {1'b0, dm1} < fill_ff[s] && hist_rd_ff[63:32] != '0;

   always_comb begin
      ev_in     = EV_COUNTED;
      pkt_in    = pkt_ff[s] + 32'd1;
      gapcnt_in = gapcnt_ff[s];
      lost_in   = lost_ff[s];
      samp_in   = samples_ff[s];
      if (restart_ff) begin
         ev_in     = EV_RESTART;
         pkt_in    = 32'd1;
         gapcnt_in = '0;
         lost_in   = '0;
      end else if (gap_hit_ff) begin
         ev_in     = EV_GAP;
         gapcnt_in = gapcnt_ff[s] + 32'd1;
         lost_in   = lost_ff[s] + gap_val_ff;
      end else if (lseq_nz_ff) begin
         samp_in   = samples_ff[s] + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:   if (q_not_empty) state_ff <= ST_LOAD;
            ST_LOAD:   state_ff <= ST_SUM;
            ST_SUM:    state_ff <= ST_SQUARE;
            ST_SQUARE: state_ff <= ST_COMMIT;
            ST_COMMIT: if (commit) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) op_ff <= q_item;
      if (state_ff == ST_LOAD) begin
         restart_ff <= session_ff[s] != op_ff.session_id;
         lseq_nz_ff <= lseq_ff[s] != '0;
         gap_hit_ff <= lseq_ff[s] != '0
                       && ({1'b0, lseq_ff[s]} + 33'd1) < {1'b0, op_ff.seq};
         gap_val_ff <= op_ff.seq - lseq_ff[s] - 32'd1;
         start_ff   <= start_in;
         length_ff  <= op_ff.now_sec - start_in;
         prod_ff    <= 54'(dsec * USEC_PER_SEC);
         udiff_ff   <= $signed({1'b0, op_ff.now_usec}) - $signed({1'b0, lusec_ff[s]});
      end
      if (state_ff == ST_SUM) t_ff <= 55'(prod_ff) + 55'(udiff_ff);
      if (state_ff == ST_SQUARE) begin
         sq_ff <= (mag[54:32] != '0) ? '1 : 64'(mag[31:0] * mag[31:0]);
         if (sum65[64] != sum65[63])
            sum_new_ff <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         else
            sum_new_ff <= sum65[63:0];
      end
      if (commit) begin
         case (op_ff.kind)
            K_NEW: begin
               ev_ff       <= EV_NEW;
               slot_out_ff <= 4'(s);
               gap_out_ff  <= '0;
               pkt_out_ff  <= 32'd1;
               loss_out_ff <= '0;
               lost_out_ff <= '0;
               samp_out_ff <= '0;
            end
            K_HIT: begin
               ev_ff       <= ev_in;
               slot_out_ff <= 4'(s);
               gap_out_ff  <= (!restart_ff && gap_hit_ff) ? gap_val_ff : '0;
               pkt_out_ff  <= pkt_in;
               loss_out_ff <= gapcnt_in;
               lost_out_ff <= lost_in;
               samp_out_ff <= samp_in;
            end
            default: begin
               ev_ff       <= (op_ff.kind == K_FULL) ? EV_FULL : EV_CLEARED;
               slot_out_ff <= '0;
               gap_out_ff  <= '0;
               pkt_out_ff  <= '0;
               loss_out_ff <= '0;
               lost_out_ff <= '0;
               samp_out_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD)
         hist_rd_ff <= hist_mem[{s, head_ff[s] + dm1}];
      if (commit && shift)
         hist_mem[{s, head_ff[s] - 1'b1}] <= restart_ff ? 64'd0 : {start_ff, length_ff};
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         case (op_ff.kind)
            K_CLEAR: begin
               for (int i = 0; i < FLOWS; i++) begin
                  samples_ff[i] <= '0;
                  sum_ff[i]     <= '0;
                  sqsum_ff[i]   <= '0;
               end
            end
            K_NEW: begin
               session_ff[s] <= op_ff.session_id;
               lseq_ff[s]    <= op_ff.seq;
               lsec_ff[s]    <= op_ff.now_sec;
               lusec_ff[s]   <= op_ff.now_usec;
               pkt_ff[s]     <= 32'd1;
               gapcnt_ff[s]  <= '0;
               lost_ff[s]    <= '0;
               ovf_ff[s]     <= '0;
               head_ff[s]    <= '0;
               fill_ff[s]    <= '0;
               samples_ff[s] <= '0;
               sum_ff[s]     <= '0;
               sqsum_ff[s]   <= '0;
            end
            K_HIT: begin
               session_ff[s] <= op_ff.session_id;
               lseq_ff[s]    <= op_ff.seq;
               lsec_ff[s]    <= op_ff.now_sec;
               lusec_ff[s]   <= op_ff.now_usec;
               pkt_ff[s]     <= pkt_in;
               gapcnt_ff[s]  <= gapcnt_in;
               lost_ff[s]    <= lost_in;
               samples_ff[s] <= samp_in;
               if (shift) begin
                  head_ff[s] <= head_ff[s] - 1'b1;
                  if (fill_ff[s] != FILL_W'(HIST_DEPTH)) fill_ff[s] <= fill_ff[s] + 1'b1;
                  if (ovf_hit && ovf_ff[s] != 16'hFFFF) ovf_ff[s] <= ovf_ff[s] + 16'd1;
               end else if (lseq_nz_ff) begin
                  sum_ff[s]   <= sum_new_ff;
                  sqsum_ff[s] <= sqsum_in;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.event_res    = ev_ff;
   assign rsp.flow_slot    = slot_out_ff;
   assign rsp.gap_packets  = gap_out_ff;
   assign rsp.packet_total = pkt_out_ff;
   assign rsp.loss_events  = loss_out_ff;
   assign rsp.lost_total   = lost_out_ff;
   assign rsp.sample_count = samp_out_ff;
endmodule
`default_nettype wire

// ----- hdl/per_flow_sequence_loss_monitor.sv -----
// Per-flow sequence loss monitor of multicast probe senders: top level.
// The front end matches each probe against the sixteen-entry flow table in the
// cycle it is taken and places it in a two-entry queue; the back end then takes
// it through pick-up, state read, time difference scaled to microseconds, square
// and signed sum, and commit in its single sequencer, which takes a new item only
// once the last is committed, holding commit while a result waits. The input is
// taken while a result waits in the output register, until the queue is full. The
// loss history is kept in a 128-entry memory as a ring per flow. No clearing pass.
`default_nettype none
module per_flow_sequence_loss_monitor
   import flm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   flm_req_if.sink   req,
   flm_rsp_if.source rsp,
   flm_csr_if.sink   csr
);
   logic       q_full, q_not_empty, push, pop;
   item_type   push_item, head_item;
   logic [3:0] depth_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) depth_ff <= DEPTH_RESET;
      else if (csr.valid) depth_ff <= csr.history_depth;
   end

   flm_front u_front (
      .clock, .reset, .req, .q_full, .push, .push_item
   );

   flm_queue u_queue (
      .clock, .reset, .push, .push_item, .pop,
      .full(q_full), .not_empty(q_not_empty), .head_item
   );

   flm_back u_back (
      .clock, .reset, .history_depth(depth_ff),
      .q_not_empty, .q_item(head_item), .pop, .rsp
   );

`ifndef NO_ASSERTIONS
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.event_res <= EV_CLEARED)
      else $error("undefined event code");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.event_res == EV_FULL |-> rsp.flow_slot == '0
      && rsp.packet_total == '0 && rsp.gap_packets == '0)
      else $error("dropped result carries data");
   a_new_one: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.event_res == EV_NEW |-> rsp.packet_total == 32'd1
      && rsp.sample_count == '0)
      else $error("new sender counters not fresh");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty)
      else $error("queue read while empty");
`endif
endmodule
`default_nettype wire
